### rtl/glyph_quad_vertex_generator_macros.svh
// Assertion macros shared by the checker files.
// Each macro names a clock, a reset that disables the check, a trigger and a consequence.
`ifndef GLYPH_QUAD_VERTEX_GENERATOR_MACROS_SVH
`define GLYPH_QUAD_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define GQVG_ASSERT_NOW(lbl, clk_s, rst_s, trig, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |-> (cons)) \
    else $error("glyph quad check failed");

// next-cycle implication
`define GQVG_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |=> (cons)) \
    else $error("glyph quad check failed");

`endif

### rtl/gqvg_pkg.sv
// Shared types and constants of the glyph quad vertex generator.
// No dependencies; every other file but the assertion macros header imports it.
package gqvg_pkg;

  localparam int GLYPH_COUNT_DEF   = 128;
  localparam int VERTEX_BUDGET_DEF = 4096;
  localparam int QUAD_VERTS        = 6;

  localparam int FIELD_W    = 12;
  localparam int CODE_W     = 8;
  localparam int ACTION_W   = 2;
  localparam int COORD_W    = 24;
  localparam int TEX_W      = 17;
  localparam int TEX_FRAC_W = 16;
  localparam int SCALE_W    = 16;
  localparam int ATLAS_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RENDER = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_READY   = 2'd3;

  // corner select per vertex, bit k for vertex k: (0,0)(1,0)(1,1)(0,0)(1,1)(0,1)
  localparam logic [QUAD_VERTS-1:0] CORNER_X = 6'b010110;
  localparam logic [QUAD_VERTS-1:0] CORNER_Y = 6'b110100;

  localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

  typedef struct packed {
    logic [FIELD_W-1:0]        atlas_x;
    logic [FIELD_W-1:0]        atlas_y;
    logic [FIELD_W-1:0]        glyph_width;
    logic [FIELD_W-1:0]        glyph_height;
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
    logic [FIELD_W-1:0]        advance;
  } glyph_t;

endpackage

### rtl/gqvg_cmd_if.sv
// Command channel: load, begin and render words.
// Uses gqvg_pkg for field widths.
interface gqvg_cmd_if import gqvg_pkg::*; ;
  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic [CODE_W-1:0]           char_code;
  logic [FIELD_W-1:0]          atlas_x;
  logic [FIELD_W-1:0]          atlas_y;
  logic [FIELD_W-1:0]          glyph_width;
  logic [FIELD_W-1:0]          glyph_height;
  logic signed [FIELD_W-1:0]   offset_x;
  logic signed [FIELD_W-1:0]   offset_y;
  logic [FIELD_W-1:0]          advance;
  logic signed [COORD_W-1:0]   start_x;
  logic signed [COORD_W-1:0]   start_y;

  modport source (
    output valid, action, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
           offset_x, offset_y, advance, start_x, start_y,
    input  ready
  );
  modport sink (
    input  valid, action, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
           offset_x, offset_y, advance, start_x, start_y,
    output ready
  );
endinterface

### rtl/gqvg_vtx_if.sv
// Vertex channel: one vertex word per handshake.
// Uses gqvg_pkg for field widths.
interface gqvg_vtx_if import gqvg_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [TEX_W-1:0]          tex_u;
  logic [TEX_W-1:0]          tex_v;
  logic                      last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, tex_u, tex_v, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, tex_u, tex_v, last_vertex,
    output ready
  );
endinterface

### rtl/gqvg_glyph_mem.sv
// Glyph table: one synchronous memory, one write and one read port, read data registered.
// Per-entry valid bits make never-loaded glyphs read as zero. Uses gqvg_pkg.
module gqvg_glyph_mem import gqvg_pkg::*; #(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [$clog2(GLYPH_COUNT)-1:0] waddr,
  input  glyph_t                         wdata,
  input  logic                           re,
  input  logic [$clog2(GLYPH_COUNT)-1:0] raddr,
  output glyph_t                         rdata
);

  glyph_t                 mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] entry_valid;
  glyph_t                 rd_q;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (we) begin
        entry_valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= entry_valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

### rtl/gqvg_div.sv
// Atlas coordinate divider: texels * 65536 / size, one quotient bit per cycle.
// Numerator at or above the divisor gives exactly one (saturated). Uses gqvg_pkg.
module gqvg_div import gqvg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ATLAS_W-1:0] num,
  input  logic [ATLAS_W-1:0] den,
  output logic               busy,
  output logic [TEX_W-1:0]   quo
);

  localparam int CNT_W = $clog2(TEX_FRAC_W);

  logic [ATLAS_W-1:0]    rem;
  logic [ATLAS_W:0]      rem2;
  logic [TEX_FRAC_W-1:0] q;
  logic                  sat;
  logic [CNT_W-1:0]      cnt;
  logic                  fits;

  assign rem2 = {rem, 1'b0};
  assign fits = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= num < den;
    end else if (busy && cnt == CNT_W'(TEX_FRAC_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      q   <= '0;
      cnt <= '0;
      sat <= num >= den;
    end else if (busy) begin
      // remainder stays below den, so the shifted value fits after the subtract
      if (fits) begin
        rem <= ATLAS_W'(rem2 - {1'b0, den});
      end else begin
        rem <= rem2[ATLAS_W-1:0];
      end
      q   <= {q[TEX_FRAC_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  assign quo = sat ? TEX_ONE : {1'b0, q};

endmodule

### rtl/glyph_quad_vertex_generator.sv
// Glyph quad vertex generator top level. Load, begin and ignored words finish in the accept
// cycle. A render word reads the glyph table, runs 6 multiply/add steps on a shared
// 13x17 multiplier while four bit-serial dividers run, then emits 6 vertex words; no new
// command word is accepted until the last vertex word is loaded. A zero-size glyph skips to
// the advance steps and emits no vertex. Reset (rst, synchronous) clears pen, count, budget,
// glyph valid bits and loads the register defaults; no clearing pass is needed.
module glyph_quad_vertex_generator import gqvg_pkg::*; #(
  parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF,
  parameter int VERTEX_BUDGET = VERTEX_BUDGET_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  gqvg_cmd_if.sink              cmd,
  gqvg_vtx_if.source            vtx,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = $clog2(GLYPH_COUNT);
  localparam int VCW = $clog2(VERTEX_BUDGET);
  localparam int PW  = FIELD_W + SCALE_W + 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_CALC  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [PW:0] v);
    if (v > 31'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -31'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

  state_t state;

  logic [SCALE_W-1:0] text_scale;
  logic [ATLAS_W-1:0] atlas_width;
  logic [ATLAS_W-1:0] atlas_height;
  logic               font_ready;

  logic signed [COORD_W-1:0] pen_x, pen_y;
  logic [VCW-1:0]            vertices_emitted;
  logic [VCW-1:0]            vertices_emitted_next;
  logic                      budget_reached;

  logic cmd_acc, code_ok, render_go, mem_we;
  glyph_t wr_glyph, rd_glyph, g;
  logic   no_quad;

  logic [2:0]                step;
  logic signed [12:0]        mul_a;
  logic signed [16:0]        mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [COORD_W-1:0] add_base;
  logic                      add_sub;
  logic signed [PW:0]        add_sum;
  logic signed [COORD_W-1:0] add_sat;
  logic signed [COORD_W-1:0] x0, y0, x1, y1;

  logic [ATLAS_W-1:0] den_u, den_v;
  logic [3:0]         div_busy;
  logic [TEX_W-1:0]   u0, u1, v0, v1;
  logic               div_start;

  logic [2:0]                vidx;
  logic                      out_load;
  logic                      vtx_valid_q;
  logic signed [COORD_W-1:0] vx_q, vy_q;
  logic [TEX_W-1:0]          tu_q, tv_q;
  logic                      last_q;

  assign cmd.ready = state == S_IDLE;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign code_ok   = {1'b0, cmd.char_code} < 9'(GLYPH_COUNT);
  assign mem_we    = cmd_acc && cmd.action == ACT_LOAD && code_ok;
  assign render_go = cmd_acc && cmd.action == ACT_RENDER && font_ready &&
                     !budget_reached && code_ok;

  always_comb begin
    wr_glyph.atlas_x      = cmd.atlas_x;
    wr_glyph.atlas_y      = cmd.atlas_y;
    wr_glyph.glyph_width  = cmd.glyph_width;
    wr_glyph.glyph_height = cmd.glyph_height;
    wr_glyph.offset_x     = cmd.offset_x;
    wr_glyph.offset_y     = cmd.offset_y;
    wr_glyph.advance      = cmd.advance;
  end

  gqvg_glyph_mem #(.GLYPH_COUNT(GLYPH_COUNT)) u_glyph_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (cmd.char_code[AW-1:0]),
    .wdata (wr_glyph),
    .re    (render_go),
    .raddr (cmd.char_code[AW-1:0]),
    .rdata (rd_glyph)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_scale   <= 16'd256;
      atlas_width  <= 13'd256;
      atlas_height <= 13'd256;
      font_ready   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_SCALE:   text_scale   <= cfg_data[SCALE_W-1:0];
        REG_ATLAS_WIDTH:  atlas_width  <= cfg_data[ATLAS_W-1:0];
        REG_ATLAS_HEIGHT: atlas_height <= cfg_data[ATLAS_W-1:0];
        REG_FONT_READY:   font_ready   <= cfg_data[0];
      endcase
    end
  end

  // dividers start from the fresh read data; a zero-size glyph never waits on them
  assign div_start = state == S_FETCH;
  assign den_u     = (atlas_width == '0) ? ATLAS_W'(1) : atlas_width;
  assign den_v     = (atlas_height == '0) ? ATLAS_W'(1) : atlas_height;

  gqvg_div u_div_u0 (
    .clk (clk), .rst (rst), .start (div_start),
    .num ({1'b0, rd_glyph.atlas_x}), .den (den_u),
    .busy (div_busy[0]), .quo (u0)
  );
  gqvg_div u_div_u1 (
    .clk (clk), .rst (rst), .start (div_start),
    .num (ATLAS_W'(rd_glyph.atlas_x) + ATLAS_W'(rd_glyph.glyph_width)), .den (den_u),
    .busy (div_busy[1]), .quo (u1)
  );
  gqvg_div u_div_v0 (
    .clk (clk), .rst (rst), .start (div_start),
    .num ({1'b0, rd_glyph.atlas_y}), .den (den_v),
    .busy (div_busy[2]), .quo (v0)
  );
  gqvg_div u_div_v1 (
    .clk (clk), .rst (rst), .start (div_start),
    .num (ATLAS_W'(rd_glyph.atlas_y) + ATLAS_W'(rd_glyph.glyph_height)), .den (den_v),
    .busy (div_busy[3]), .quo (v1)
  );

  // shared multiplier: step n multiplies, step n+1 adds the registered product
  always_comb begin
    mul_b = {1'b0, text_scale};
    case (step)
      3'd0:    mul_a = {g.offset_x[FIELD_W-1], g.offset_x};
      3'd1:    mul_a = {g.offset_y[FIELD_W-1], g.offset_y};
      3'd2:    mul_a = {1'b0, g.glyph_width};
      3'd3:    mul_a = {1'b0, g.glyph_height};
      default: mul_a = {1'b0, g.advance};
    endcase
  end

  always_comb begin
    case (step)
      3'd1:    begin add_base = pen_x; add_sub = 1'b0; end
      3'd2:    begin add_base = pen_y; add_sub = 1'b1; end
      3'd3:    begin add_base = x0;    add_sub = 1'b0; end
      3'd4:    begin add_base = y0;    add_sub = 1'b1; end
      default: begin add_base = pen_x; add_sub = 1'b0; end
    endcase
    if (add_sub) begin
      add_sum = (PW+1)'(add_base) - (PW+1)'(prod);
    end else begin
      add_sum = (PW+1)'(add_base) + (PW+1)'(prod);
    end
    add_sat = sat24(add_sum);
  end

  assign out_load              = state == S_EMIT && (!vtx_valid_q || vtx.ready);
  assign vertices_emitted_next = vertices_emitted + VCW'(QUAD_VERTS);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      step             <= '0;
      vidx             <= '0;
      pen_x            <= '0;
      pen_y            <= '0;
      vertices_emitted <= '0;
      budget_reached   <= 1'b0;
      vtx_valid_q      <= 1'b0;
    end else begin
      if (out_load) begin
        vtx_valid_q <= 1'b1;
      end else if (vtx.ready) begin
        vtx_valid_q <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc && cmd.action == ACT_BEGIN) begin
            pen_x            <= cmd.start_x;
            pen_y            <= cmd.start_y;
            vertices_emitted <= '0;
            budget_reached   <= 1'b0;
          end
          if (render_go) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // zero-size glyph: skip straight to the advance product
          step  <= (rd_glyph.glyph_width == '0 || rd_glyph.glyph_height == '0) ? 3'd4 : 3'd0;
          state <= S_CALC;
        end
        S_CALC: begin
          step <= step + 1'b1;
          if (step == 3'd5) begin
            pen_x <= add_sat;
            state <= no_quad ? S_IDLE : S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_busy == '0) begin
            vidx  <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            vidx <= vidx + 1'b1;
            if (vidx == 3'(QUAD_VERTS - 1)) begin
              vertices_emitted <= vertices_emitted_next;
              if (vertices_emitted_next >= VCW'(VERTEX_BUDGET - QUAD_VERTS)) begin
                budget_reached <= 1'b1;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      g       <= rd_glyph;
      no_quad <= rd_glyph.glyph_width == '0 || rd_glyph.glyph_height == '0;
    end
    if (state == S_CALC) begin
      prod <= mul_a * mul_b;
      case (step)
        3'd1:    x0 <= add_sat;
        3'd2:    y0 <= add_sat;
        3'd3:    x1 <= add_sat;
        3'd4:    y1 <= add_sat;
        default: ;
      endcase
    end
    if (out_load) begin
      vx_q   <= CORNER_X[vidx] ? x1 : x0;
      vy_q   <= CORNER_Y[vidx] ? y1 : y0;
      tu_q   <= CORNER_X[vidx] ? u1 : u0;
      tv_q   <= CORNER_Y[vidx] ? v1 : v0;
      last_q <= vidx == 3'(QUAD_VERTS - 1);
    end
  end

  assign vtx.valid       = vtx_valid_q;
  assign vtx.vertex_x    = vx_q;
  assign vtx.vertex_y    = vy_q;
  assign vtx.tex_u       = tu_q;
  assign vtx.tex_v       = tv_q;
  assign vtx.last_vertex = last_q;

endmodule

### rtl/gqvg_checker.sv
// Port-level checks for the glyph quad vertex generator, bound to the top level.
// Uses the assertion macros header and gqvg_pkg.
`include "glyph_quad_vertex_generator_macros.svh"

module gqvg_checker import gqvg_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_ready,
  input logic                      vtx_valid,
  input logic                      vtx_ready,
  input logic                      vtx_last,
  input logic signed [COORD_W-1:0] vertex_x,
  input logic signed [COORD_W-1:0] vertex_y,
  input logic [TEX_W-1:0]          tex_u,
  input logic [TEX_W-1:0]          tex_v
);

  // reset leaves no word pending and the command side open
  `GQVG_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !vtx_valid && cmd_ready)

  // a stalled vertex word holds
  `GQVG_ASSERT_NEXT(a_vtx_hold, clk, rst, vtx_valid && !vtx_ready,
    vtx_valid && $stable(vertex_x) && $stable(vertex_y) && $stable(tex_u) && $stable(tex_v))

  // commands stay blocked until the sixth vertex of a quad is out
  `GQVG_ASSERT_NOW(a_busy_mid_quad, clk, rst, vtx_valid && !vtx_last, !cmd_ready)

endmodule

bind glyph_quad_vertex_generator gqvg_checker u_gqvg_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .vtx_valid (vtx.valid),
  .vtx_ready (vtx.ready),
  .vtx_last  (vtx.last_vertex),
  .vertex_x  (vtx.vertex_x),
  .vertex_y  (vtx.vertex_y),
  .tex_u     (vtx.tex_u),
  .tex_v     (vtx.tex_v)
);

### tb/sv/gqvg_quad_checker.sv
// Checker for the glyph quad vertex generator: watches the command, vertex and register ports,
// predicts each quad and compares every vertex word in order.
// Depends on gqvg_pkg and the gqvg_cmd_if / gqvg_vtx_if interfaces.
module gqvg_quad_checker import gqvg_pkg::*; #(
  parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF,
  parameter int VERTEX_BUDGET = VERTEX_BUDGET_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  gqvg_cmd_if                   cmd,
  gqvg_vtx_if                   vtx,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    vertices_seen,
  output int                    quads_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // vertex k takes the right column / lower row when bit k is set
  localparam logic [QUAD_VERTS-1:0] RIGHT_COLUMN = 6'b010110;
  localparam logic [QUAD_VERTS-1:0] LOWER_ROW    = 6'b110100;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [TEX_W-1:0]          u;
    logic [TEX_W-1:0]          v;
    logic                      last_vertex;
  } vertex_t;

  glyph_t                    glyph_tab [GLYPH_COUNT];
  logic signed [COORD_W-1:0] pen_x;
  logic signed [COORD_W-1:0] pen_y;
  logic [12:0]               emitted;
  logic                      budget_hit;
  logic [SCALE_W-1:0]        scale;
  logic [ATLAS_W-1:0]        atlas_w;
  logic [ATLAS_W-1:0]        atlas_h;
  logic                      font_loaded;
  vertex_t                   quad_vertices [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    vertices_seen = 0;
    quads_seen    = 0;
  end

  function automatic logic signed [COORD_W-1:0] clamp24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[COORD_W-1:0];
  endfunction

  // texel position over atlas size in Q1.16, an empty atlas size counts as one
  function automatic logic [TEX_W-1:0] tex_coord(int texels, logic [ATLAS_W-1:0] size);
    longint d;
    longint q;
    d = (size == '0) ? 1 : longint'(size);
    q = (longint'(texels) << TEX_FRAC_W) / d;
    return (q > longint'(TEX_ONE)) ? TEX_ONE : q[TEX_W-1:0];
  endfunction

  task automatic place_glyph(input logic [CODE_W-1:0] code);
    glyph_t                    g;
    logic signed [COORD_W-1:0] xs [2];
    logic signed [COORD_W-1:0] ys [2];
    logic [TEX_W-1:0]          us [2];
    logic [TEX_W-1:0]          vs [2];
    vertex_t                   vert;
    longint                    step;
    g    = glyph_tab[code];
    step = longint'(g.advance) * longint'(scale);
    // empty glyph: advance only
    if (g.glyph_width == '0 || g.glyph_height == '0) begin
      pen_x = clamp24(longint'(pen_x) + step);
      return;
    end
    xs[0] = clamp24(longint'(pen_x) + longint'($signed(g.offset_x)) * longint'(scale));
    ys[0] = clamp24(longint'(pen_y) - longint'($signed(g.offset_y)) * longint'(scale));
    xs[1] = clamp24(longint'(xs[0]) + longint'(g.glyph_width) * longint'(scale));
    ys[1] = clamp24(longint'(ys[0]) - longint'(g.glyph_height) * longint'(scale));
    us[0] = tex_coord(int'(g.atlas_x), atlas_w);
    us[1] = tex_coord(int'(g.atlas_x) + int'(g.glyph_width), atlas_w);
    vs[0] = tex_coord(int'(g.atlas_y), atlas_h);
    vs[1] = tex_coord(int'(g.atlas_y) + int'(g.glyph_height), atlas_h);
    for (int k = 0; k < QUAD_VERTS; k++) begin
      vert.x           = xs[RIGHT_COLUMN[k]];
      vert.y           = ys[LOWER_ROW[k]];
      vert.u           = us[RIGHT_COLUMN[k]];
      vert.v           = vs[LOWER_ROW[k]];
      vert.last_vertex = (k == QUAD_VERTS - 1);
      quad_vertices.push_back(vert);
    end
    pen_x   = clamp24(longint'(pen_x) + step);
    emitted = emitted + 13'(QUAD_VERTS);
    if (int'(emitted) >= VERTEX_BUDGET - QUAD_VERTS) budget_hit = 1'b1;
  endtask

  task automatic apply_word();
    glyph_t g;
    g.atlas_x      = cmd.atlas_x;
    g.atlas_y      = cmd.atlas_y;
    g.glyph_width  = cmd.glyph_width;
    g.glyph_height = cmd.glyph_height;
    g.offset_x     = cmd.offset_x;
    g.offset_y     = cmd.offset_y;
    g.advance      = cmd.advance;
    case (cmd.action)
      ACT_LOAD: begin
        if (int'(cmd.char_code) < GLYPH_COUNT) glyph_tab[cmd.char_code] = g;
      end
      ACT_BEGIN: begin
        pen_x      = cmd.start_x;
        pen_y      = cmd.start_y;
        emitted    = '0;
        budget_hit = 1'b0;
      end
      ACT_RENDER: begin
        if (font_loaded && !budget_hit && int'(cmd.char_code) < GLYPH_COUNT)
          place_glyph(cmd.char_code);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_vertex();
    vertex_t got;
    vertex_t want;
    got = '{vtx.vertex_x, vtx.vertex_y, vtx.tex_u, vtx.tex_v, vtx.last_vertex};
    vertices_seen++;
    if (got.last_vertex) quads_seen++;
    if (quad_vertices.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: vertex word with none pending: x=%0d y=%0d u=%0d v=%0d last=%0b",
                 $realtime, got.x, got.y, got.u, got.v, got.last_vertex);
    end else begin
      want = quad_vertices.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("%0t: vertex mismatch: expected x=%0d y=%0d u=%0d v=%0d last=%0b",
                   $realtime, want.x, want.y, want.u, want.v, want.last_vertex);
          $display("%0t:                  got      x=%0d y=%0d u=%0d v=%0d last=%0b",
                   $realtime, got.x, got.y, got.u, got.v, got.last_vertex);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GLYPH_COUNT; i++) glyph_tab[i] = '0;
      pen_x       = '0;
      pen_y       = '0;
      emitted     = '0;
      budget_hit  = 1'b0;
      scale       = 16'd256;
      atlas_w     = 13'd256;
      atlas_h     = 13'd256;
      font_loaded = 1'b0;
      quad_vertices.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEXT_SCALE:   scale       = cfg_data[SCALE_W-1:0];
          REG_ATLAS_WIDTH:  atlas_w     = cfg_data[ATLAS_W-1:0];
          REG_ATLAS_HEIGHT: atlas_h     = cfg_data[ATLAS_W-1:0];
          REG_FONT_READY:   font_loaded = cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.valid && cmd.ready) apply_word();
      if (vtx.valid && vtx.ready) check_vertex();
    end
    pending = quad_vertices.size();
  end

endmodule

### tb/sv/tb_top.sv
// Top of the glyph quad vertex generator bench: clock, reset, command and register stimulus,
// vertex back-pressure, watchdog and verdict. Checking lives in gqvg_quad_checker.
// Depends on gqvg_pkg, the channel interfaces, the block and the checker.
module tb_top import gqvg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPHS        = GLYPH_COUNT_DEF;
  localparam int BUDGET        = 60;     // small, so that strings run into the vertex budget
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_WORDS   = 32;
  localparam int RANDOM_PHASES = 6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic [CODE_W-1:0]         code;
    glyph_t                    glyph;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
  } cmd_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;
  int                    fail_count;
  int                    pending;
  int                    vertices_seen;
  int                    quads_seen;
  int                    stall_cycles;
  int                    words_sent;
  int                    settings_used;

  gqvg_cmd_if cmd_bus ();
  gqvg_vtx_if vtx_bus ();

  glyph_quad_vertex_generator #(
    .GLYPH_COUNT   (GLYPHS),
    .VERTEX_BUDGET (BUDGET)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .vtx       (vtx_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gqvg_quad_checker #(
    .GLYPH_COUNT   (GLYPHS),
    .VERTEX_BUDGET (BUDGET)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_bus),
    .vtx           (vtx_bus),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .vertices_seen (vertices_seen),
    .quads_seen    (quads_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // vertex back-pressure: random stall bursts, none once calm
  initial begin
    vtx_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        vtx_bus.ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        vtx_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (vtx_bus.valid && vtx_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic glyph_t make_glyph(int ax, int ay, int w, int h, int ox, int oy, int adv);
    glyph_t g;
    g.atlas_x      = 12'(ax);
    g.atlas_y      = 12'(ay);
    g.glyph_width  = 12'(w);
    g.glyph_height = 12'(h);
    g.offset_x     = 12'(ox);
    g.offset_y     = 12'(oy);
    g.advance      = 12'(adv);
    return g;
  endfunction

  function automatic glyph_t random_glyph();
    glyph_t g;
    if ($urandom_range(0, 1) == 0) begin
      g = make_glyph($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      // stay inside a typical atlas so coordinates do not pin at one
      g = make_glyph($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(1, 48),
                     $urandom_range(1, 48), int'($urandom_range(0, 40)) - 20,
                     int'($urandom_range(0, 60)) - 20, $urandom_range(0, 60));
    end
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) g.glyph_width = '0;
      else g.glyph_height = '0;
    end
    return g;
  endfunction

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.action  = ACTION_W'($urandom_range(0, 3));
    w.code    = CODE_W'($urandom);
    w.glyph   = make_glyph($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    w.start_x = COORD_W'($urandom);
    w.start_y = COORD_W'($urandom);
    return w;
  endfunction

  function automatic cmd_word_t load_word(int code, glyph_t g);
    cmd_word_t w;
    w        = random_word();
    w.action = ACT_LOAD;
    w.code   = CODE_W'(code);
    w.glyph  = g;
    return w;
  endfunction

  function automatic cmd_word_t begin_word(int x, int y);
    cmd_word_t w;
    w         = random_word();
    w.action  = ACT_BEGIN;
    w.start_x = COORD_W'(x);
    w.start_y = COORD_W'(y);
    return w;
  endfunction

  function automatic cmd_word_t render_word(int code);
    cmd_word_t w;
    w        = random_word();
    w.action = ACT_RENDER;
    w.code   = CODE_W'(code);
    return w;
  endfunction

  task automatic drive_fields(input cmd_word_t w);
    cmd_bus.action       = w.action;
    cmd_bus.char_code    = w.code;
    cmd_bus.atlas_x      = w.glyph.atlas_x;
    cmd_bus.atlas_y      = w.glyph.atlas_y;
    cmd_bus.glyph_width  = w.glyph.glyph_width;
    cmd_bus.glyph_height = w.glyph.glyph_height;
    cmd_bus.offset_x     = w.glyph.offset_x;
    cmd_bus.offset_y     = w.glyph.offset_y;
    cmd_bus.advance      = w.glyph.advance;
    cmd_bus.start_x      = w.start_x;
    cmd_bus.start_y      = w.start_y;
  endtask

  // called at a falling edge; leaves valid high so back-to-back words need no gap
  task automatic push_word(input cmd_word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_bus.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    drive_fields(w);
    cmd_bus.valid = 1'b1;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drain: all vertices back, then let a trailing empty glyph finish
  task automatic settle();
    cmd_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int scale, int aw, int ah, int ready);
    settle();
    write_reg(REG_TEXT_SCALE, CFG_DATA_W'(scale));
    write_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(aw));
    write_reg(REG_ATLAS_HEIGHT, CFG_DATA_W'(ah));
    write_reg(REG_FONT_READY, CFG_DATA_W'(ready));
    settings_used++;
  endtask

  function automatic int random_start();
    if ($urandom_range(0, 3) == 0) return int'($signed(COORD_W'($urandom)));
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  function automatic int random_code();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 15);
  endfunction

  // mostly well-formed strings (begin, then renders), some loads, some noise
  task automatic random_phase(int count);
    int n;
    int len;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        push_word(random_word());
        n++;
      end else if (pick <= 2) begin
        push_word(load_word(random_code(), random_glyph()));
        n++;
      end else begin
        len = $urandom_range(1, 12);
        push_word(begin_word(random_start(), random_start()));
        repeat (len) push_word(render_word(random_code()));
        n += len + 1;
      end
    end
  endtask

  initial begin
    cmd_word_t idle_word;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_TEXT_SCALE;
    cfg_data      = '0;
    calm          = 1'b0;
    words_sent    = 0;
    settings_used = 1;
    stall_cycles  = 0;
    idle_word     = '{ACT_LOAD, '0, '0, '0, '0};
    drive_fields(idle_word);
    cmd_bus.valid = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // font not ready yet: loads and begins take effect, renders are dropped
    push_word(load_word(0, make_glyph(4095, 4095, 4095, 4095, 2047, -2048, 4095)));
    push_word(load_word(1, make_glyph(0, 0, 1, 1, -2048, 2047, 0)));
    push_word(load_word(2, make_glyph(10, 10, 0, 5, 0, 0, 100)));
    push_word(load_word(3, make_glyph(20, 20, 7, 0, 1, 1, 9)));
    push_word(load_word(127, make_glyph(100, 50, 20, 30, 2, 25, 22)));
    push_word(load_word(200, random_glyph()));
    push_word(load_word(255, random_glyph()));
    push_word(render_word(0));
    cmd_bus.valid = 1'b0;
    idle_word        = render_word(0);
    idle_word.action = ACT_UNUSED;
    push_word(idle_word);
    push_word(begin_word(100 << 8, 200 << 8));
    push_word(render_word(127));

    configure(256, 256, 256, 1);
    push_word(render_word(127));
    push_word(render_word(2));
    push_word(render_word(127));
    push_word(begin_word(8388607, -8388608));
    push_word(render_word(0));
    push_word(render_word(3));
    push_word(render_word(200));
    push_word(render_word(255));
    push_word(render_word(1));
    push_word(begin_word(-8388608, 8388607));
    push_word(render_word(1));
    push_word(render_word(0));
    push_word(render_word(10));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(65535, 1, 4096, 1);
        1: configure(0, 4096, 1, 1);
        2: configure($urandom_range(64, 1024), 0, 0, 1);
        3: configure($urandom_range(0, 65535), $urandom_range(1, 4096),
                     $urandom_range(1, 4096), 0);
        4: configure($urandom_range(1, 65535), $urandom_range(1, 4096),
                     $urandom_range(1, 4096), 1);
        default: begin
          configure(256, $urandom_range(1, 4096), $urandom_range(1, 4096), 1);
          calm = 1'b1;
        end
      endcase
      random_phase(PHASE_WORDS);
    end

    cmd_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d command words under %0d register settings", words_sent, settings_used);
    $display("checked %0d vertex words in %0d quads, %0d failures", vertices_seen, quads_seen,
             fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
